// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files; morse_key_decoder_core.sv includes them.
// They expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/mkd_pkg.sv =====
`timescale 1ns / 1ps
package mkd_pkg;

    localparam int unsigned TickWidth = 16;
    localparam int unsigned CodeWidth = 6;
    localparam int unsigned CountWidth = 3;
    localparam int unsigned CharWidth = 7;
    localparam int unsigned MaxSymbols = 5;
    localparam int unsigned CfgAddrWidth = 5;

    localparam logic [CountWidth-1:0] CountOverlong = 3'd6;
    localparam logic [CodeWidth-1:0] CodeSentinel = 6'd1;
    localparam logic [CharWidth-1:0] CharInvalid = 7'h3F;
    localparam logic [TickWidth-1:0] TickMax = 16'hFFFF;

    localparam logic [2:0] RegDebounce = 3'd0;
    localparam logic [2:0] RegDotMin = 3'd1;
    localparam logic [2:0] RegDashMin = 3'd2;
    localparam logic [2:0] RegDashMax = 3'd3;
    localparam logic [2:0] RegLed = 3'd4;
    localparam logic [2:0] RegGap = 3'd5;

    localparam logic [TickWidth-1:0] DebounceReset = 16'd156;
    localparam logic [TickWidth-1:0] DotMinReset = 16'd781;
    localparam logic [TickWidth-1:0] DashMinReset = 16'd3125;
    localparam logic [TickWidth-1:0] DashMaxReset = 16'd6250;
    localparam logic [TickWidth-1:0] LedReset = 16'd781;
    localparam logic [TickWidth-1:0] GapReset = 16'd6250;

    typedef struct packed {
        logic [TickWidth-1:0] settle_ticks;
        logic [TickWidth-1:0] short_min_ticks;
        logic [TickWidth-1:0] long_min_ticks;
        logic [TickWidth-1:0] long_max_ticks;
        logic [TickWidth-1:0] led_ticks;
        logic [TickWidth-1:0] gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic                 dash_lamp;
        logic                 dot_lamp;
        logic [CharWidth-1:0] char_code;
        logic                 char_valid;
    } t_result;

    function automatic logic [CharWidth-1:0] letter_of(input logic [CodeWidth-1:0] code);
        logic [CharWidth-1:0] c;
        case (code)
            6'd2:    c = 7'h45; // E
            6'd3:    c = 7'h54; // T
            6'd4:    c = 7'h49; // I
            6'd5:    c = 7'h41; // A
            6'd6:    c = 7'h4E; // N
            6'd7:    c = 7'h4D; // M
            6'd8:    c = 7'h53; // S
            6'd9:    c = 7'h55; // U
            6'd10:   c = 7'h52; // R
            6'd11:   c = 7'h57; // W
            6'd12:   c = 7'h44; // D
            6'd13:   c = 7'h4B; // K
            6'd14:   c = 7'h47; // G
            6'd15:   c = 7'h4F; // O
            6'd16:   c = 7'h48; // H
            6'd17:   c = 7'h56; // V
            6'd18:   c = 7'h46; // F
            6'd20:   c = 7'h4C; // L
            6'd22:   c = 7'h50; // P
            6'd23:   c = 7'h4A; // J
            6'd24:   c = 7'h42; // B
            6'd25:   c = 7'h58; // X
            6'd26:   c = 7'h43; // C
            6'd27:   c = 7'h59; // Y
            6'd28:   c = 7'h5A; // Z
            6'd29:   c = 7'h51; // Q
            6'd32:   c = 7'h35; // 5
            6'd33:   c = 7'h34; // 4
            6'd35:   c = 7'h33; // 3
            6'd39:   c = 7'h32; // 2
            6'd47:   c = 7'h31; // 1
            6'd48:   c = 7'h36; // 6
            6'd56:   c = 7'h37; // 7
            6'd60:   c = 7'h38; // 8
            6'd62:   c = 7'h39; // 9
            6'd63:   c = 7'h30; // 0
            default: c = CharInvalid;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/mkd_cfg.sv =====
`timescale 1ns / 1ps
module mkd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mkd_pkg::CfgAddrWidth-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output mkd_pkg::t_cfg                   o_cfg
);
    import mkd_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks    <= DebounceReset;
            r_cfg.short_min_ticks <= DotMinReset;
            r_cfg.long_min_ticks  <= DashMinReset;
            r_cfg.long_max_ticks  <= DashMaxReset;
            r_cfg.led_ticks       <= LedReset;
            r_cfg.gap_ticks       <= GapReset;
        end else if (w_wr) begin
            case (w_idx)
                RegDebounce: r_cfg.settle_ticks    <= pwdata[TickWidth-1:0];
                RegDotMin:   r_cfg.short_min_ticks <= pwdata[TickWidth-1:0];
                RegDashMin:  r_cfg.long_min_ticks  <= pwdata[TickWidth-1:0];
                RegDashMax:  r_cfg.long_max_ticks  <= pwdata[TickWidth-1:0];
                RegLed:      r_cfg.led_ticks       <= pwdata[TickWidth-1:0];
                RegGap:      r_cfg.gap_ticks       <= pwdata[TickWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            RegDebounce: prdata = {16'd0, r_cfg.settle_ticks};
            RegDotMin:   prdata = {16'd0, r_cfg.short_min_ticks};
            RegDashMin:  prdata = {16'd0, r_cfg.long_min_ticks};
            RegDashMax:  prdata = {16'd0, r_cfg.long_max_ticks};
            RegLed:      prdata = {16'd0, r_cfg.led_ticks};
            RegGap:      prdata = {16'd0, r_cfg.gap_ticks};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/mkd_tracker.sv =====
`timescale 1ns / 1ps
module mkd_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  mkd_pkg::t_cfg    i_cfg,
    output mkd_pkg::t_result o_result
);
    import mkd_pkg::*;

    logic                  r_last_level, n_last_level;
    logic                  r_key_held, n_key_held;
    logic [TickWidth-1:0]  r_tick, n_tick;
    logic [CodeWidth-1:0]  r_bits, n_bits;
    logic [CountWidth-1:0] r_count, n_count;
    logic                  r_gap_armed, n_gap_armed;
    logic                  r_lamp_armed, n_lamp_armed;
    logic [1:0]            r_lamp, n_lamp;
    logic                  w_push, w_dash, w_emit;
    logic [CharWidth-1:0]  w_code;

    always_comb begin
        n_key_held   = r_key_held;
        n_tick       = r_tick;
        n_bits       = r_bits;
        n_count      = r_count;
        n_gap_armed  = r_gap_armed;
        n_lamp_armed = r_lamp_armed;
        n_lamp       = r_lamp;
        w_push       = 1'b0;
        w_dash       = 1'b0;
        w_emit       = 1'b0;
        w_code       = '0;

        if (!r_key_held && i_level && !r_last_level) begin
            if (r_tick >= i_cfg.settle_ticks) begin
                n_gap_armed  = 1'b0;
                n_lamp_armed = 1'b0;
                n_lamp       = 2'b00;
                n_key_held   = 1'b1;
                n_tick       = '0;
            end
        end else if (r_key_held && !i_level && r_last_level) begin
            if (r_tick >= i_cfg.short_min_ticks) begin
                if (r_tick < i_cfg.long_min_ticks) begin
                    w_push = 1'b1;
                    n_lamp = 2'b01;
                end else if (r_tick <= i_cfg.long_max_ticks) begin
                    w_push = 1'b1;
                    w_dash = 1'b1;
                    n_lamp = 2'b10;
                end
                n_key_held   = 1'b0;
                n_tick       = '0;
                n_gap_armed  = 1'b1;
                n_lamp_armed = 1'b1;
            end
        end

        if (w_push) begin
            if (r_count < CountWidth'(MaxSymbols)) begin
                n_bits  = {r_bits[CodeWidth-2:0], w_dash};
                n_count = r_count + 1'b1;
            end else begin
                n_count = CountOverlong;
            end
        end

        if (n_lamp_armed && n_tick >= i_cfg.led_ticks) begin
            n_lamp       = 2'b00;
            n_lamp_armed = 1'b0;
        end

        if (n_gap_armed && n_tick >= i_cfg.gap_ticks) begin
            if (!n_key_held && n_count != '0) begin
                w_emit = 1'b1;
                w_code = (n_count > CountWidth'(MaxSymbols)) ? CharInvalid : letter_of(n_bits);
                n_bits  = CodeSentinel;
                n_count = '0;
            end
            n_lamp       = 2'b00;
            n_gap_armed  = 1'b0;
            n_lamp_armed = 1'b0;
        end

        if (n_tick != TickMax) begin
            n_tick = n_tick + 1'b1;
        end
        n_last_level = i_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_key_held   <= 1'b0;
            r_tick       <= '0;
            r_bits       <= CodeSentinel;
            r_count      <= '0;
            r_gap_armed  <= 1'b0;
            r_lamp_armed <= 1'b0;
            r_lamp       <= 2'b00;
        end else if (i_step) begin
            r_last_level <= n_last_level;
            r_key_held   <= n_key_held;
            r_tick       <= n_tick;
            r_bits       <= n_bits;
            r_count      <= n_count;
            r_gap_armed  <= n_gap_armed;
            r_lamp_armed <= n_lamp_armed;
            r_lamp       <= n_lamp;
        end
    end

    assign o_result.char_valid = w_emit;
    assign o_result.char_code  = w_code;
    assign o_result.dot_lamp   = n_lamp[0];
    assign o_result.dash_lamp  = n_lamp[1];

endmodule

// ===== sv/morse_key_decoder_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Morse key timing decoder.
// The slave stream takes one sampled key level per beat (tdata bit 0, 1 when
// pressed). For every input beat the master stream gives exactly one result
// beat carrying the character strobe, the decoded ASCII code and the two
// indicator drives. Timing thresholds are set through the APB port and are
// counted in input beats, not clock cycles.
// An input beat is captured in an input register; the timing, symbol and
// lookup logic then updates the decoder state from it and loads the result
// register once that register is empty or its beat is being taken.
// One beat per cycle is sustained while the receiver holds tready high; the
// state update between the two registers is combinational.
// When the receiver stalls, the result is held and at most one further input
// beat is taken into the input register, after which the slave tready drops.
// Synchronous reset empties both registers, clears the decoder state to an
// empty letter with lamps off and loads the default thresholds.
module morse_key_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [0] key_level, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [0] char_valid, [7:1] char_code,
                                    // [8] dot_lamp, [9] dash_lamp, [15:10] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mkd_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    logic    w_step;
    logic    w_in_take;

    mkd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mkd_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_level  (r_in_level),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_step    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_step;
    assign w_in_take = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_level <= i_s_tdata[0];
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_result};

    `ASSERT_IMPLY(a_code_with_strobe, i_clk, i_rst_n,
        r_out_valid && r_result.char_valid, r_result.char_code != '0,
        "character strobe without a code")
    `ASSERT_IMPLY(a_code_zero_idle, i_clk, i_rst_n,
        r_out_valid && !r_result.char_valid, r_result.char_code == '0,
        "code present without a character strobe")
    `ASSERT_IMPLY(a_one_lamp, i_clk, i_rst_n,
        r_out_valid, !(r_result.dot_lamp && r_result.dash_lamp),
        "both lamps lit at once")
    `ASSERT_NEXT(a_stall_keeps_input, i_clk, i_rst_n,
        w_in_take && r_out_valid && !i_m_tready && !w_step, r_in_valid,
        "input beat lost during output stall")

endmodule

// ===== bench/tb_morse_key_decoder_core.sv =====
`timescale 1ns / 1ps
module tb_morse_key_decoder_core;
    import mkd_pkg::*;

    localparam logic [2:0] RegSpareA = 3'd6;
    localparam logic [2:0] RegSpareB = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [0] key_level, [7:1] zero
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [0] char_valid, [7:1] char_code, [8] dot_lamp,
                                   // [9] dash_lamp, [15:10] zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    morse_key_decoder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the thresholds and of the decoder state.
    t_cfg                  cfg;
    logic                  prev_level;
    logic                  held;
    logic [TickWidth-1:0]  ticks;
    logic [CodeWidth-1:0]  code_bits;
    logic [CountWidth-1:0] code_len;
    logic                  gap_on;
    logic                  lamp_on;
    logic [1:0]            lamps;
    byte unsigned          letter_table [64];

    logic    key_levels [$];
    t_result expected_results [$];
    t_result got;
    t_result want;

    int queued = 0;
    int samples_done = 0;
    int results_seen = 0;
    int chars_decoded = 0;
    int chars_invalid = 0;
    int settings_used = 0;
    int failures = 0;
    int burst_left = 0;
    int idle_left = 0;
    int hold_left = 0;

    initial begin
        foreach (letter_table[i]) letter_table[i] = "?";
        letter_table[2] = "E";  letter_table[3] = "T";  letter_table[4] = "I";
        letter_table[5] = "A";  letter_table[6] = "N";  letter_table[7] = "M";
        letter_table[8] = "S";  letter_table[9] = "U";  letter_table[10] = "R";
        letter_table[11] = "W"; letter_table[12] = "D"; letter_table[13] = "K";
        letter_table[14] = "G"; letter_table[15] = "O"; letter_table[16] = "H";
        letter_table[17] = "V"; letter_table[18] = "F"; letter_table[20] = "L";
        letter_table[22] = "P"; letter_table[23] = "J"; letter_table[24] = "B";
        letter_table[25] = "X"; letter_table[26] = "C"; letter_table[27] = "Y";
        letter_table[28] = "Z"; letter_table[29] = "Q"; letter_table[32] = "5";
        letter_table[33] = "4"; letter_table[35] = "3"; letter_table[39] = "2";
        letter_table[47] = "1"; letter_table[48] = "6"; letter_table[56] = "7";
        letter_table[60] = "8"; letter_table[62] = "9"; letter_table[63] = "0";
    end

    function automatic t_result decode_tick(input logic level);
        t_result r;
        logic    dash;
        r = '0;
        if (!held && level && !prev_level) begin
            if (ticks >= cfg.settle_ticks) begin
                gap_on = 1'b0;
                lamp_on = 1'b0;
                lamps = 2'b00;
                held = 1'b1;
                ticks = '0;
            end
        end else if (held && !level && prev_level) begin
            if (ticks >= cfg.short_min_ticks) begin
                if (ticks < cfg.long_min_ticks || ticks <= cfg.long_max_ticks) begin
                    dash = (ticks >= cfg.long_min_ticks);
                    if (code_len < MaxSymbols) begin
                        code_bits = {code_bits[CodeWidth-2:0], dash};
                        code_len = code_len + 1'b1;
                    end else begin
                        code_len = CountOverlong;
                    end
                    lamps = dash ? 2'b10 : 2'b01;
                end
                held = 1'b0;
                ticks = '0;
                gap_on = 1'b1;
                lamp_on = 1'b1;
            end
        end
        if (lamp_on && ticks >= cfg.led_ticks) begin
            lamps = 2'b00;
            lamp_on = 1'b0;
        end
        if (gap_on && ticks >= cfg.gap_ticks) begin
            if (!held && code_len != 0) begin
                r.char_valid = 1'b1;
                r.char_code = (code_len > MaxSymbols) ? CharInvalid
                                                      : letter_table[code_bits][CharWidth-1:0];
                code_bits = CodeSentinel;
                code_len = '0;
            end
            lamps = 2'b00;
            gap_on = 1'b0;
            lamp_on = 1'b0;
        end
        if (ticks != TickMax) ticks = ticks + 1'b1;
        prev_level = level;
        r.dot_lamp = lamps[0];
        r.dash_lamp = lamps[1];
        return r;
    endfunction

    function automatic void report_failure(input string what);
        if (failures < 10) $display("%s", what);
        failures++;
    endfunction

    // Key sender: bursts of random length separated by short gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left <= 0;
            idle_left <= 0;
            cfg = '{settle_ticks: DebounceReset, short_min_ticks: DotMinReset,
                    long_min_ticks: DashMinReset, long_max_ticks: DashMaxReset,
                    led_ticks: LedReset, gap_ticks: GapReset};
            prev_level = 1'b0;
            held = 1'b0;
            ticks = '0;
            code_bits = CodeSentinel;
            code_len = '0;
            gap_on = 1'b0;
            lamp_on = 1'b0;
            lamps = 2'b00;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(decode_tick(i_s_tdata[0]));
                samples_done++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                    i_s_tvalid <= 1'b0;
                end else if (key_levels.size() != 0) begin
                    i_s_tdata <= {7'b0, key_levels.pop_front()};
                    i_s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 20);
                        idle_left <= $urandom_range(0, 3);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: ready runs and stalls of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    i_m_tready <= 1'b0;
                    hold_left <= $urandom_range(0, 3);
                end
                2: begin
                    i_m_tready <= 1'b1;
                    hold_left <= $urandom_range(50, 200);
                end
                default: begin
                    i_m_tready <= 1'b1;
                    hold_left <= $urandom_range(0, 19);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[9:0];
            if (expected_results.size() == 0) begin
                report_failure($sformatf("Result beat %h arrived with nothing expected",
                                         o_m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
                    got.dot_lamp !== want.dot_lamp || got.dash_lamp !== want.dash_lamp) begin
                    report_failure($sformatf(
                        "Beat %0d: expected valid %0b code %h dot %0b dash %0b, got %0b %h %0b %0b",
                        results_seen, want.char_valid, want.char_code, want.dot_lamp,
                        want.dash_lamp, got.char_valid, got.char_code, got.dot_lamp,
                        got.dash_lamp));
                end
            end
            results_seen++;
            if (got.char_valid) chars_decoded++;
            if (got.char_valid && got.char_code == CharInvalid) chars_invalid++;
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic [2:0] idx);
        logic [31:0]          rd;
        logic [TickWidth-1:0] expected_value;
        case (idx)
            RegDebounce: expected_value = cfg.settle_ticks;
            RegDotMin:   expected_value = cfg.short_min_ticks;
            RegDashMin:  expected_value = cfg.long_min_ticks;
            RegDashMax:  expected_value = cfg.long_max_ticks;
            RegLed:      expected_value = cfg.led_ticks;
            default:     expected_value = cfg.gap_ticks;
        endcase
        apb_access(1'b0, idx, '0, rd);
        if (rd !== {16'b0, expected_value})
            report_failure($sformatf("Register %0d reads %h, expected %h",
                                     idx, rd, expected_value));
    endtask

    task automatic write_register(input logic [2:0] idx, input int value);
        logic [31:0] rd;
        apb_access(1'b1, idx, {16'b0, value[15:0]}, rd);
        case (idx)
            RegDebounce: cfg.settle_ticks = value[15:0];
            RegDotMin:   cfg.short_min_ticks = value[15:0];
            RegDashMin:  cfg.long_min_ticks = value[15:0];
            RegDashMax:  cfg.long_max_ticks = value[15:0];
            RegLed:      cfg.led_ticks = value[15:0];
            RegGap:      cfg.gap_ticks = value[15:0];
            default:     ;
        endcase
        if (idx <= RegGap) check_register(idx);
    endtask

    task automatic set_thresholds(input int db, input int dot_min, input int dash_min,
                                  input int dash_max, input int led, input int gap);
        write_register(RegDebounce, db);
        write_register(RegDotMin, dot_min);
        write_register(RegDashMin, dash_min);
        write_register(RegDashMax, dash_max);
        write_register(RegLed, led);
        write_register(RegGap, gap);
        settings_used++;
    endtask

    task automatic wait_idle();
        while (key_levels.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_run(input logic level, input int n);
        repeat (n) key_levels.push_back(level);
        queued += n;
    endtask

    task automatic add_noise(input int n);
        int   left;
        int   len;
        logic level;
        left = n;
        level = $urandom_range(0, 1);
        while (left > 0) begin
            len = $urandom_range(1, 15);
            if (len > left) len = left;
            add_run(level, len);
            left -= len;
            level = !level;
        end
    endtask

    // A letter keyed within the current thresholds, ended by a full gap.
    task automatic add_letter(input int symbols);
        int lo;
        lo = (cfg.settle_ticks == 0) ? 1 : cfg.settle_ticks;
        for (int s = 0; s < symbols; s++) begin
            if ($urandom_range(0, 1))
                add_run(1'b1, $urandom_range(cfg.long_min_ticks, cfg.long_max_ticks));
            else
                add_run(1'b1, $urandom_range(cfg.short_min_ticks, cfg.long_min_ticks - 1));
            if (s < symbols - 1)
                add_run(1'b0, $urandom_range(lo, (cfg.gap_ticks > lo) ? cfg.gap_ticks : lo));
            else
                add_run(1'b0, cfg.gap_ticks + $urandom_range(1, 4));
        end
    endtask

    task automatic random_phase(input int n);
        int dot_min;
        int dash_min;
        int dash_max;
        int gap;
        int target;
        dot_min = $urandom_range(1, 4);
        dash_min = dot_min + $urandom_range(1, 4);
        dash_max = dash_min + $urandom_range(0, 5);
        gap = $urandom_range(3, 12);
        set_thresholds($urandom_range(0, 4), dot_min, dash_min, dash_max,
                       $urandom_range(0, 8), gap);
        target = queued + n;
        add_run(1'b0, gap + 2);
        while (queued < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_noise($urandom_range(4, 30));
                    add_run(1'b0, gap + 2);
                end
                1: begin
                    add_run(1'b1, dash_max + $urandom_range(1, 6));
                    add_run(1'b0, gap + $urandom_range(1, 4));
                end
                2: add_letter($urandom_range(6, 7));
                default: add_letter($urandom_range(1, 5));
            endcase
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        for (int r = 0; r <= RegGap; r++) check_register(r[2:0]);

        set_thresholds(2, 2, 4, 6, 2, 8);
        write_register(RegSpareA, 1);
        write_register(RegSpareB, 16'hFFFF);
        add_run(1'b0, 3);
        add_run(1'b1, 1); add_run(1'b0, 1); add_run(1'b1, 1); add_run(1'b0, 3);
        add_run(1'b1, 5); add_run(1'b0, 1); add_run(1'b1, 6); add_run(1'b0, 9);
        add_run(1'b1, 7); add_run(1'b0, 9);
        repeat (6) begin
            add_run(1'b1, 2);
            add_run(1'b0, 2);
        end
        add_run(1'b0, 8);
        add_run(1'b1, 2); add_run(1'b0, 2); add_run(1'b1, 3); add_run(1'b0, 2);
        add_run(1'b1, 4); add_run(1'b0, 2); add_run(1'b1, 6); add_run(1'b0, 10);
        wait_idle();

        set_thresholds(0, 0, 0, 0, 0, 0);
        add_noise(60);
        wait_idle();
        set_thresholds(0, 0, 0, 16'hFFFF, 0, 0);
        add_noise(60);
        wait_idle();

        random_phase(250);
        random_phase(250);

        // Every threshold at its top: no press is accepted.
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_run(1'b0, 20); add_run(1'b1, 3); add_run(1'b0, 20);
        add_run(1'b1, 2); add_run(1'b0, 4);
        wait_idle();

        random_phase(250);
        random_phase(250);

        while (key_levels.size() != 0 || i_s_tvalid) @(posedge i_clk);
        for (int k = 0; k < 1000 && expected_results.size() != 0; k++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_failure($sformatf("%0d result beats never arrived",
                                     expected_results.size()));
        $display("Sent %0d key beats under %0d threshold settings; %0d result beats checked.",
                 samples_done, settings_used, results_seen);
        $display("Decoded %0d characters, %0d of them invalid; %0d failures.",
                 chars_decoded, chars_invalid, failures);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
